// ----- sv/wstd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wstd_pkg
// shared types and constants for the task dispatcher
// ----------------------------------------------------------------------------
package wstd_pkg;

   localparam int CORE_LIMIT  = 16;
   localparam int QDEPTH      = 1024;
   localparam int TASK_W      = 16;
   localparam int CORE_W      = $clog2(CORE_LIMIT);
   localparam int QPTR_W      = $clog2(QDEPTH);
   localparam int QFILL_W     = QPTR_W + 1;
   localparam int CCOUNT_W    = 5;
   localparam int LOC_ADDR_W  = CORE_W + QPTR_W;

   localparam logic [1:0] CMD_ADD      = 2'd0;
   localparam logic [1:0] CMD_DISPATCH = 2'd1;
   localparam logic [1:0] CMD_REPORT   = 2'd2;

   localparam logic [1:0] OUT_RUNNABLE = 2'd0;

   localparam logic [1:0] SRC_NONE   = 2'd0;
   localparam logic [1:0] SRC_LOCAL  = 2'd1;
   localparam logic [1:0] SRC_GLOBAL = 2'd2;
   localparam logic [1:0] SRC_STOLEN = 2'd3;

   localparam logic [CCOUNT_W-1:0] CORE_COUNT_RESET = CCOUNT_W'(2);

   typedef struct packed {
      logic [1:0]        cmd;
      logic [CORE_W-1:0] core_index;
      logic [TASK_W-1:0] task_id;
      logic [1:0]        outcome;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic               task_valid;
      logic [TASK_W-1:0]  granted_task;
      logic [1:0]         source;
      logic [QFILL_W-1:0] batch_moved;
      logic [CORE_W-1:0]  victim_core;
   } rsp_type;

endpackage
`default_nettype wire

// ----- sv/work_stealing_task_dispatcher_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// work_stealing_task_dispatcher_unit
// global fifo plus one local deque per core, with batch refill and stealing
// ----------------------------------------------------------------------------
// One word is handled at a time; req_ready is low from acceptance until the
// response word has left the output register. An add, a report, an unknown
// command or a dispatch from a core not in use passes through accept, decode
// and response; a local pop adds the local read (S_LREAD, S_LDONE). A global
// batch refill first divides the global fill by core_count with one shared
// subtractor, one step a cycle, then moves each task with one global read
// and one local write. A steal scans the cores one per cycle using a single
// fill-count compare. The response is held in the output register while
// rsp_ready stays low. The global and local stores have no reset; per-core
// head and fill counters live in flip-flops, so no clearing pass is needed
// after reset.
module work_stealing_task_dispatcher_unit (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  wstd_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output wstd_pkg::rsp_type           rsp_data,
   input  wire                         csr_we,
   input  wire [wstd_pkg::CCOUNT_W-1:0] csr_wdata
);
   import wstd_pkg::*;

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_BREAD = 3'd2;  // batch: global read issued
   localparam logic [2:0] S_BWRITE = 3'd3; // batch: local write
   localparam logic [2:0] S_SCAN  = 3'd4;  // steal scan, one core per cycle
   localparam logic [2:0] S_LREAD = 3'd5;  // local read issued
   localparam logic [2:0] S_LDONE = 3'd6;  // local read data back
   localparam logic [2:0] S_RESP  = 3'd7;

   logic [2:0]  state_ff, state_in;
   logic [CCOUNT_W-1:0] ccount_ff;
   req_type     req_ff;
   rsp_type     rsp_ff, rsp_in;

   logic [TASK_W-1:0]  gmem [QDEPTH];
   logic [TASK_W-1:0]  lmem [CORE_LIMIT*QDEPTH];
   logic [QPTR_W-1:0]  ghead_ff;
   logic [QFILL_W-1:0] gfill_ff;
   logic [QPTR_W-1:0]  lhead_ff [CORE_LIMIT];
   logic [QFILL_W-1:0] lfill_ff [CORE_LIMIT];

   logic [QFILL_W-1:0] cnt_ff, cnt_in;    // batch moves left
   logic [QFILL_W-1:0] quot_ff, quot_in;  // shared divider quotient
   logic [QFILL_W-1:0] rem_ff, rem_in;    // divider remainder
   logic [CORE_W-1:0]  scan_ff, scan_in;  // steal scan index
   logic               div_busy_ff, div_busy_in;

   logic [TASK_W-1:0]  gdata_ff, ldata_ff;
   logic [LOC_ADDR_W-1:0] lraddr;
   logic               lrd_en, lwr_en, grd_en, gwr_en;
   logic [LOC_ADDR_W-1:0] lwaddr;
   logic [TASK_W-1:0]  lwdata;
   logic [QPTR_W-1:0]  gaddr;

   // effective core count, 0 acts as 1 and large values clamp
   logic [CCOUNT_W-1:0] ncore;
   always_comb begin
      if (ccount_ff == '0) ncore = CCOUNT_W'(1);
      else if (ccount_ff > CCOUNT_W'(CORE_LIMIT)) ncore = CCOUNT_W'(CORE_LIMIT);
      else ncore = ccount_ff;
   end

   logic [CORE_W-1:0] core;
   logic core_ok;
   assign core    = req_ff.core_index;
   assign core_ok = {1'b0, core} < ncore;

   logic [QFILL_W-1:0] lfill_c;
   logic [QPTR_W-1:0]  lhead_c;
   assign lfill_c = lfill_ff[core];
   assign lhead_c = lhead_ff[core];

   logic [QFILL_W-1:0] scan_fill;
   assign scan_fill = lfill_ff[scan_ff];

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_data  = rsp_ff;

   // memories
   always_ff @(posedge clock) begin
      if (gwr_en) gmem[gaddr] <= req_ff.task_id;
      if (grd_en) gdata_ff <= gmem[gaddr];
      if (lwr_en) lmem[lwaddr] <= lwdata;
      if (lrd_en) ldata_ff <= lmem[lraddr];
   end

   // sequencer
   logic            g_pop, l_push, l_pop_front, l_pop_back, batch_done;
   logic [CORE_W-1:0] pop_core;
   always_comb begin
      state_in    = state_ff;
      rsp_in      = rsp_ff;
      cnt_in      = cnt_ff;
      quot_in     = quot_ff;
      rem_in      = rem_ff;
      scan_in     = scan_ff;
      div_busy_in = div_busy_ff;
      gwr_en = 1'b0; grd_en = 1'b0; lwr_en = 1'b0; lrd_en = 1'b0;
      gaddr  = ghead_ff + gfill_ff[QPTR_W-1:0];
      lwaddr = {core, lhead_c + lfill_c[QPTR_W-1:0]};
      lwdata = req_ff.task_id;
      lraddr = {core, lhead_c};
      g_pop = 1'b0; l_push = 1'b0; l_pop_front = 1'b0; l_pop_back = 1'b0;
      batch_done = 1'b0;
      pop_core = core;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECODE;
               rsp_in   = '0;
            end
         end
         S_DECODE: begin
            state_in = S_RESP;
            unique case (req_ff.cmd)
               CMD_ADD: begin
                  if (gfill_ff < QFILL_W'(QDEPTH)) begin
                     gwr_en = 1'b1;
                     rsp_in.accepted = 1'b1;
                  end
               end
               CMD_REPORT: begin
                  if (core_ok && req_ff.outcome == OUT_RUNNABLE &&
                      lfill_c < QFILL_W'(QDEPTH)) begin
                     lwr_en = 1'b1;
                     l_push = 1'b1;
                     rsp_in.accepted = 1'b1;
                  end
               end
               CMD_DISPATCH: begin
                  if (!core_ok) begin
                     state_in = S_RESP;
                  end else if (lfill_c != '0) begin
                     lrd_en = 1'b1;
                     rsp_in.source = SRC_LOCAL;
                     state_in = S_LREAD;
                  end else if (gfill_ff != '0) begin
                     // quotient by repeated subtraction, one step a cycle
                     if (!div_busy_ff) begin
                        div_busy_in = 1'b1;
                        quot_in = '0;
                        rem_in  = gfill_ff;
                        state_in = S_DECODE;
                     end else if (rem_ff >= QFILL_W'(ncore)) begin
                        rem_in  = rem_ff - QFILL_W'(ncore);
                        quot_in = quot_ff + QFILL_W'(1);
                        state_in = S_DECODE;
                     end else begin
                        div_busy_in = 1'b0;
                        cnt_in = (quot_ff + QFILL_W'(1) > gfill_ff) ?
                                 gfill_ff : quot_ff + QFILL_W'(1);
                        rsp_in.source = SRC_GLOBAL;
                        rsp_in.batch_moved = (quot_ff + QFILL_W'(1) > gfill_ff) ?
                                 gfill_ff : quot_ff + QFILL_W'(1);
                        state_in = S_BREAD;
                     end
                  end else begin
                     scan_in  = '0;
                     state_in = S_SCAN;
                  end
               end
               default: state_in = S_RESP;
            endcase
         end
         S_BREAD: begin
            gaddr  = ghead_ff;
            grd_en = 1'b1;
            g_pop  = 1'b1;
            state_in = S_BWRITE;
         end
         S_BWRITE: begin
            // local queue is empty, so slot index is moved count so far
            lwaddr = {core, lhead_c + QPTR_W'(rsp_ff.batch_moved - cnt_ff)};
            lwdata = gdata_ff;
            lwr_en = 1'b1;
            cnt_in = cnt_ff - QFILL_W'(1);
            if (cnt_ff == QFILL_W'(1)) begin
               batch_done = 1'b1;
               state_in = S_LREAD;
            end else begin
               state_in = S_BREAD;
            end
         end
         S_LREAD: begin
            lrd_en = 1'b1;
            l_pop_front = 1'b1;
            state_in = S_LDONE;
         end
         S_SCAN: begin
            if ({1'b0, scan_ff} >= ncore) begin
               state_in = S_RESP;
            end else if (scan_ff != core && scan_fill != '0) begin
               pop_core = scan_ff;
               lraddr = {scan_ff, lhead_ff[scan_ff] +
                         QPTR_W'(scan_fill - QFILL_W'(1))};
               lrd_en = 1'b1;
               l_pop_back = 1'b1;
               rsp_in.source = SRC_STOLEN;
               rsp_in.victim_core = scan_ff;
               state_in = S_LDONE;
            end else if (scan_ff == CORE_W'(CORE_LIMIT-1)) begin
               state_in = S_RESP;
            end else begin
               scan_in = scan_ff + CORE_W'(1);
            end
         end
         S_LDONE: begin
            rsp_in.task_valid   = 1'b1;
            rsp_in.granted_task = ldata_ff;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         ccount_ff   <= CORE_COUNT_RESET;
         ghead_ff    <= '0;
         gfill_ff    <= '0;
         div_busy_ff <= 1'b0;
         for (int i = 0; i < CORE_LIMIT; i++) begin
            lhead_ff[i] <= '0;
            lfill_ff[i] <= '0;
         end
      end else begin
         state_ff    <= state_in;
         div_busy_ff <= div_busy_in;
         if (csr_we) ccount_ff <= csr_wdata;
         if (gwr_en) gfill_ff <= gfill_ff + QFILL_W'(1);
         if (g_pop) begin
            ghead_ff <= ghead_ff + QPTR_W'(1);
            gfill_ff <= gfill_ff - QFILL_W'(1);
         end
         if (l_push) lfill_ff[core] <= lfill_c + QFILL_W'(1);
         if (batch_done) lfill_ff[core] <= rsp_ff.batch_moved;
         if (l_pop_front) begin
            lhead_ff[core] <= lhead_c + QPTR_W'(1);
            lfill_ff[core] <= lfill_c - QFILL_W'(1);
         end
         if (l_pop_back) lfill_ff[pop_core] <= scan_fill - QFILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) req_ff <= req_data;
      rsp_ff  <= rsp_in;
      cnt_ff  <= cnt_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      scan_ff <= scan_in;
   end

endmodule
`default_nettype wire
